// File: sv/owm_pkg.sv
package owm_pkg;

	// bus sequencer phases
	typedef enum logic [3:0] {
		PH_IDLE,
		PH_RLOW,
		PH_RWAIT,
		PH_RREC,
		PH_WLOW,
		PH_WREL,
		PH_RDLOW,
		PH_RDREL,
		PH_CONV
	} phase_t;

	// operation codes carried by an input item
	localparam logic [1:0] OP_RESET = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	localparam logic [1:0] OP_TEMP  = 2'd3;

	// configuration register indexes
	localparam int unsigned NUM_REGS = 6;
	localparam int unsigned IDX_W = 3;
	localparam logic [IDX_W-1:0] REG_RESET_LOW   = 3'd0;
	localparam logic [IDX_W-1:0] REG_PRES_WAIT   = 3'd1;
	localparam logic [IDX_W-1:0] REG_SLOT        = 3'd2;
	localparam logic [IDX_W-1:0] REG_WR1_LOW     = 3'd3;
	localparam logic [IDX_W-1:0] REG_RD_LOW      = 3'd4;
	localparam logic [IDX_W-1:0] REG_CONV_WAIT   = 3'd5;

	localparam int unsigned TIME_W = 10;

	// register values after reset
	localparam logic [TIME_W-1:0] DEF_RESET_LOW = 10'd480;
	localparam logic [TIME_W-1:0] DEF_PRES_WAIT = 10'd60;
	localparam logic [TIME_W-1:0] DEF_SLOT      = 10'd60;
	localparam logic [TIME_W-1:0] DEF_WR1_LOW   = 10'd1;
	localparam logic [TIME_W-1:0] DEF_RD_LOW    = 10'd2;
	localparam logic [TIME_W-1:0] DEF_CONV_WAIT = 10'd600;

	// sensor commands
	localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
	localparam logic [7:0] CMD_CONVERT  = 8'h44;
	localparam logic [7:0] CMD_READ_PAD = 8'hBE;

	// steps of the temperature read sequence
	localparam logic [3:0] SEQ_RESET1   = 4'd0;
	localparam logic [3:0] SEQ_SKIP1    = 4'd1;
	localparam logic [3:0] SEQ_CONVERT  = 4'd2;
	localparam logic [3:0] SEQ_WAIT     = 4'd3;
	localparam logic [3:0] SEQ_RESET2   = 4'd4;
	localparam logic [3:0] SEQ_SKIP2    = 4'd5;
	localparam logic [3:0] SEQ_READ_CMD = 4'd6;
	localparam logic [3:0] SEQ_LOW_BYTE = 4'd7;
	localparam logic [3:0] SEQ_HI_BYTE  = 4'd8;

	// timing registers
	typedef struct packed {
		logic [TIME_W-1:0] reset_low_time;
		logic [TIME_W-1:0] presence_wait_time;
		logic [TIME_W-1:0] slot_time;
		logic [TIME_W-1:0] write_one_low_time;
		logic [TIME_W-1:0] read_low_time;
		logic [TIME_W-1:0] convert_wait_time;
	} cfg_t;

	// sequencer state
	typedef struct packed {
		phase_t            phase;
		logic [TIME_W-1:0] micro_cnt;
		logic [2:0]        bit_idx;
		logic [7:0]        shift_byte;
		logic [3:0]        seq_step;
		logic [7:0]        low_byte_hold;
		logic              absent;
		logic [11:0]       temp_hold;
		logic [1:0]        op_kind;
		logic [7:0]        read_hold;
	} state_t;

	// one input item
	typedef struct packed {
		logic       line_level;
		logic [7:0] write_byte;
		logic [1:0] operation;
		logic       start_req;
	} item_t;

	// per-tick bus flags
	typedef struct packed {
		logic pull;
		logic busy;
		logic done;
	} tick_t;

endpackage

// File: sv/owm_cfg.sv
module owm_cfg
	import owm_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    we,
	input  logic [IDX_W-1:0]        index,
	input  logic [TIME_W-1:0]       data,
	output cfg_t                    cfg
);

	cfg_t cfg_q;

	// register file, out-of-range indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_low_time     <= DEF_RESET_LOW;
			cfg_q.presence_wait_time <= DEF_PRES_WAIT;
			cfg_q.slot_time          <= DEF_SLOT;
			cfg_q.write_one_low_time <= DEF_WR1_LOW;
			cfg_q.read_low_time      <= DEF_RD_LOW;
			cfg_q.convert_wait_time  <= DEF_CONV_WAIT;
		end else if (we) begin
			case (index)
				REG_RESET_LOW: cfg_q.reset_low_time     <= data;
				REG_PRES_WAIT: cfg_q.presence_wait_time <= data;
				REG_SLOT:      cfg_q.slot_time          <= data;
				REG_WR1_LOW:   cfg_q.write_one_low_time <= data;
				REG_RD_LOW:    cfg_q.read_low_time      <= data;
				REG_CONV_WAIT: cfg_q.convert_wait_time  <= data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: sv/owm_step.sv
module owm_step
	import owm_pkg::*;
(
	input  cfg_t   cfg,
	input  state_t cur,
	input  item_t  item,
	output state_t nxt,
	output tick_t  tick
);

	// next piece of the temperature sequence after one piece ends
	function automatic state_t end_piece(input state_t s);
		state_t r;
		r = s;
		if (s.op_kind == OP_TEMP) begin
			case (s.seq_step)
				SEQ_RESET1: begin
					if (s.absent) begin
						r.temp_hold = '0;
					end else begin
						r.seq_step = SEQ_SKIP1;
						r.shift_byte = CMD_SKIP_ROM;
						r.bit_idx = '0;
						r.micro_cnt = '0;
						r.phase = PH_WLOW;
					end
				end
				SEQ_SKIP1: begin
					r.seq_step = SEQ_CONVERT;
					r.shift_byte = CMD_CONVERT;
					r.bit_idx = '0;
					r.micro_cnt = '0;
					r.phase = PH_WLOW;
				end
				SEQ_CONVERT: begin
					r.seq_step = SEQ_WAIT;
					r.micro_cnt = '0;
					r.phase = PH_CONV;
				end
				SEQ_WAIT: begin
					r.seq_step = SEQ_RESET2;
					r.micro_cnt = '0;
					r.phase = PH_RLOW;
				end
				SEQ_RESET2: begin
					r.seq_step = SEQ_SKIP2;
					r.shift_byte = CMD_SKIP_ROM;
					r.bit_idx = '0;
					r.micro_cnt = '0;
					r.phase = PH_WLOW;
				end
				SEQ_SKIP2: begin
					r.seq_step = SEQ_READ_CMD;
					r.shift_byte = CMD_READ_PAD;
					r.bit_idx = '0;
					r.micro_cnt = '0;
					r.phase = PH_WLOW;
				end
				SEQ_READ_CMD: begin
					r.seq_step = SEQ_LOW_BYTE;
					r.shift_byte = '0;
					r.bit_idx = '0;
					r.micro_cnt = '0;
					r.phase = PH_RDLOW;
				end
				SEQ_LOW_BYTE: begin
					r.low_byte_hold = s.shift_byte;
					r.seq_step = SEQ_HI_BYTE;
					r.shift_byte = '0;
					r.bit_idx = '0;
					r.micro_cnt = '0;
					r.phase = PH_RDLOW;
				end
				default: begin
					// 16-bit word shifted right by four
					r.temp_hold = {s.shift_byte, s.low_byte_hold[7:4]};
				end
			endcase
		end
		return r;
	endfunction

	// whole operation ends with this piece
	function automatic logic op_ends(input state_t s);
		return (s.op_kind != OP_TEMP) || (s.seq_step >= SEQ_HI_BYTE) ||
			((s.seq_step == SEQ_RESET1) && s.absent);
	endfunction

	state_t            s;
	logic [TIME_W-1:0] dur;
	logic [TIME_W:0]   cnt_inc;
	logic              bitv;
	logic              fin;

	always_comb begin
		s = cur;
		tick = '0;
		dur = 10'd1;
		fin = 1'b0;
		bitv = 1'b0;
		cnt_inc = '0;

		// start is only seen while idle
		if (s.phase == PH_IDLE && item.start_req) begin
			s.op_kind = item.operation;
			s.seq_step = SEQ_RESET1;
			s.micro_cnt = '0;
			s.bit_idx = '0;
			case (item.operation)
				OP_WRITE: begin
					s.shift_byte = item.write_byte;
					s.phase = PH_WLOW;
				end
				OP_READ: begin
					s.shift_byte = '0;
					s.phase = PH_RDLOW;
				end
				default: s.phase = PH_RLOW;
			endcase
		end

		if (s.phase != PH_IDLE) begin
			tick.busy = 1'b1;
			bitv = s.shift_byte[s.bit_idx];

			// drive level, duration and samples of the current phase
			case (s.phase)
				PH_RLOW: begin
					tick.pull = 1'b1;
					dur = cfg.reset_low_time;
				end
				PH_RWAIT: dur = cfg.presence_wait_time;
				PH_RREC: begin
					if (s.micro_cnt == '0) s.absent = item.line_level;
					dur = cfg.reset_low_time;
				end
				PH_WLOW: begin
					tick.pull = 1'b1;
					dur = bitv ? cfg.write_one_low_time : cfg.slot_time;
				end
				PH_WREL: dur = cfg.slot_time;
				PH_RDLOW: begin
					tick.pull = 1'b1;
					dur = cfg.read_low_time;
				end
				PH_RDREL: begin
					if (s.micro_cnt == '0 && item.line_level) s.shift_byte[s.bit_idx] = 1'b1;
					dur = cfg.slot_time;
				end
				default: dur = cfg.convert_wait_time;
			endcase
			if (dur == '0) dur = 10'd1;

			// phase timer and transitions
			cnt_inc = {1'b0, s.micro_cnt} + 11'd1;
			if (cnt_inc >= {1'b0, dur}) begin
				s.micro_cnt = '0;
				case (s.phase)
					PH_RLOW:  s.phase = PH_RWAIT;
					PH_RWAIT: s.phase = PH_RREC;
					PH_WLOW, PH_WREL: begin
						if (s.phase == PH_WLOW && bitv) begin
							s.phase = PH_WREL;
						end else if (s.bit_idx == 3'd7) begin
							fin = op_ends(s);
							s = end_piece(s);
						end else begin
							s.bit_idx = s.bit_idx + 3'd1;
							s.phase = PH_WLOW;
						end
					end
					PH_RDLOW: s.phase = PH_RDREL;
					PH_RDREL: begin
						if (s.bit_idx == 3'd7) begin
							s.read_hold = s.shift_byte;
							fin = op_ends(s);
							s = end_piece(s);
						end else begin
							s.bit_idx = s.bit_idx + 3'd1;
							s.phase = PH_RDLOW;
						end
					end
					default: begin
						fin = op_ends(s);
						s = end_piece(s);
					end
				endcase
				if (fin) begin
					s.phase = PH_IDLE;
					tick.done = 1'b1;
				end
			end else begin
				s.micro_cnt = cnt_inc[TIME_W-1:0];
			end
		end
		nxt = s;
	end

endmodule

// File: sv/one_wire_master_temperature_read.sv
// One-wire bus master with a built-in temperature read sequence.
// Every input transfer on s_* is one microsecond tick of the bus: it carries
// the sampled line level and, while the master is idle, an optional start
// with an operation code (reset, write byte, read byte, temperature read).
// Every input transfer yields exactly one output transfer on m_* holding the
// bus drive for that tick, busy/done flags, the presence result, the last
// byte read and the last temperature word.
// Timing registers are written through cfg_we/cfg_index/cfg_data while no
// tick is in flight; this binds the user, as the block does not enforce it.
// Indexes past the last register are ignored. An accepted tick goes from the
// input register to the result register once free, then shows on m_tdata.
// One tick per cycle while m_tready is high; the sequencer state is updated
// once per tick by a single combinational step between the input and result
// register. When m_tready is low the result register holds, the input
// register keeps one further tick and s_tready drops until the result is
// taken. Reset clears the sequencer to idle, all held results to zero and
// the timing registers to their defaults (480, 60, 60, 1, 2, 600 us).
module one_wire_master_temperature_read
	import owm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	// start_req[0], operation[2:1], write_byte[10:3], line_level[11], zero[15:12]
	input  logic [15:0]       s_tdata,
	output logic              m_tvalid,
	input  logic              m_tready,
	// bus_pull_low[0], busy_res[1], done_res[2], no_device[3], read_byte[11:4],
	// temperature[23:12]
	output logic [23:0]       m_tdata,
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [TIME_W-1:0] cfg_data
);

	cfg_t   cfg;
	state_t state_q;
	state_t state_nxt;
	tick_t  tick;
	item_t  item_s1;
	logic   valid_s1;
	logic   out_valid_q;
	logic [23:0] out_data_q;
	logic   advance;

	owm_cfg u_cfg (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (cfg_we),
		.index (cfg_index),
		.data  (cfg_data),
		.cfg   (cfg)
	);

	owm_step u_step (
		.cfg (cfg),
		.cur (state_q),
		.item(item_s1),
		.nxt (state_nxt),
		.tick(tick)
	);

	// handshake between input register and result register
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// control and sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			state_q     <= '{phase: PH_IDLE, default: '0};
		end else begin
			if (s_tready) valid_s1 <= s_tvalid;
			if (advance) begin
				out_valid_q <= 1'b1;
				state_q     <= state_nxt;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) item_s1 <= s_tdata[11:0];
		if (advance) begin
			out_data_q <= {state_nxt.temp_hold, state_nxt.read_hold, state_nxt.absent,
				tick.done, tick.busy, tick.pull};
		end
	end

	// a finishing tick is always a busy tick
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		advance && tick.done |-> tick.busy)
		else $error("done without busy");

	// a finishing tick leaves the sequencer idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		advance && tick.done |=> state_q.phase == PH_IDLE)
		else $error("sequencer not idle after done");

	// idle sequencer has its timer cleared
	a_idle_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == PH_IDLE |-> state_q.micro_cnt == '0)
		else $error("timer running while idle");

	// a held tick is not lost
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("pending tick dropped");

	// the bus is only driven during an operation
	a_pull_busy: assert property (@(posedge clk) disable iff (!arst_n)
		advance && tick.pull |-> state_nxt.phase != PH_IDLE || tick.done)
		else $error("bus driven while idle");

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;
	import owm_pkg::*;

	localparam int HOLD_CYCLES = 300;

	// one result transfer, lowest field last
	typedef struct packed {
		logic [11:0] temp;
		logic [7:0]  rdata;
		logic        absent;
		logic        done;
		logic        busy;
		logic        pull;
	} tick_result_t;

	typedef enum logic [1:0] {ROW_IDLE, ROW_OP, ROW_CFG} row_kind_t;

	// how the simulated sensor answers on the line
	typedef enum logic [2:0] {
		LN_RAND,
		LN_LOW,
		LN_HIGH,
		LN_PRESENT,
		LN_ABSENT,
		LN_FIRST_ONLY
	} line_mode_t;

	// for ROW_CFG a is the register index and b the value, else operation and byte
	typedef struct packed {
		row_kind_t  kind;
		logic [9:0] a;
		logic [9:0] b;
		line_mode_t line;
		logic       typed;
	} dir_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [15:0]       s_tdata = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [23:0]       m_tdata;
	logic              cfg_we = 1'b0;
	logic [IDX_W-1:0]  cfg_index = '0;
	logic [TIME_W-1:0] cfg_data = '0;

	// predicted sequencer state and timing registers
	cfg_t              tm = '{DEF_RESET_LOW, DEF_PRES_WAIT, DEF_SLOT, DEF_WR1_LOW,
		DEF_RD_LOW, DEF_CONV_WAIT};
	phase_t            ph = PH_IDLE;
	logic [TIME_W-1:0] mcnt = '0;
	logic [2:0]        bit_idx = '0;
	logic [7:0]        shift = '0;
	logic [3:0]        seq = SEQ_RESET1;
	logic [7:0]        low_hold = '0;
	logic              absent = 1'b0;
	logic [11:0]       temp_hold = '0;
	logic [1:0]        op_kind = OP_RESET;
	logic [7:0]        read_hold = '0;

	tick_result_t      want_q[$];
	tick_result_t      got_r, want_r;
	dir_row_t          dir_rows[$];
	int                mismatches = 0;
	int                send_idle = 0;
	int                recv_stall = 0;
	logic              hold_req = 1'b0;
	int                hold_left = 0;
	int                sent_ticks = 0;
	int                done_ops = 0;

	one_wire_master_temperature_read i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// sequencer helpers
	function automatic void start_write(logic [7:0] b);
		shift = b;
		bit_idx = '0;
		mcnt = '0;
		ph = PH_WLOW;
	endfunction

	function automatic void start_read();
		shift = '0;
		bit_idx = '0;
		mcnt = '0;
		ph = PH_RDLOW;
	endfunction

	function automatic void start_reset();
		mcnt = '0;
		ph = PH_RLOW;
	endfunction

	// one piece of an operation is over; 1 when the operation is complete
	function automatic logic finish_piece();
		if (op_kind != OP_TEMP)
			return 1'b1;
		case (seq)
			SEQ_RESET1: begin
				if (absent) begin
					temp_hold = '0;
					return 1'b1;
				end
				seq = SEQ_SKIP1;
				start_write(CMD_SKIP_ROM);
			end
			SEQ_SKIP1: begin
				seq = SEQ_CONVERT;
				start_write(CMD_CONVERT);
			end
			SEQ_CONVERT: begin
				seq = SEQ_WAIT;
				mcnt = '0;
				ph = PH_CONV;
			end
			SEQ_WAIT: begin
				seq = SEQ_RESET2;
				start_reset();
			end
			SEQ_RESET2: begin
				seq = SEQ_SKIP2;
				start_write(CMD_SKIP_ROM);
			end
			SEQ_SKIP2: begin
				seq = SEQ_READ_CMD;
				start_write(CMD_READ_PAD);
			end
			SEQ_READ_CMD: begin
				seq = SEQ_LOW_BYTE;
				start_read();
			end
			SEQ_LOW_BYTE: begin
				low_hold = shift;
				seq = SEQ_HI_BYTE;
				start_read();
			end
			default: begin
				temp_hold = {shift, low_hold[7:4]};
				return 1'b1;
			end
		endcase
		return 1'b0;
	endfunction

	function automatic logic next_write_bit();
		if (bit_idx == 3'd7)
			return finish_piece();
		bit_idx++;
		ph = PH_WLOW;
		return 1'b0;
	endfunction

	// advance the predicted master by one bus tick
	function automatic tick_result_t step_bus_master(item_t it);
		tick_result_t r;
		logic [TIME_W-1:0] dur;
		logic bitv;
		logic fin;
		r = '0;
		fin = 1'b0;
		dur = '0;
		if (ph == PH_IDLE && it.start_req) begin
			op_kind = it.operation;
			seq = SEQ_RESET1;
			case (it.operation)
				OP_WRITE: start_write(it.write_byte);
				OP_READ:  start_read();
				default:  start_reset();
			endcase
		end
		if (ph != PH_IDLE) begin
			r.busy = 1'b1;
			bitv = shift[bit_idx];
			case (ph)
				PH_RLOW: begin
					r.pull = 1'b1;
					dur = tm.reset_low_time;
				end
				PH_RWAIT: dur = tm.presence_wait_time;
				PH_RREC: begin
					if (mcnt == 0)
						absent = it.line_level;
					dur = tm.reset_low_time;
				end
				PH_WLOW: begin
					r.pull = 1'b1;
					dur = bitv ? tm.write_one_low_time : tm.slot_time;
				end
				PH_WREL: dur = tm.slot_time;
				PH_RDLOW: begin
					r.pull = 1'b1;
					dur = tm.read_low_time;
				end
				PH_RDREL: begin
					if (mcnt == 0 && it.line_level)
						shift[bit_idx] = 1'b1;
					dur = tm.slot_time;
				end
				default: dur = tm.convert_wait_time;
			endcase
			// a zero register counts as one tick
			if (dur == 0)
				dur = 10'd1;
			mcnt++;
			if (mcnt >= dur) begin
				mcnt = '0;
				case (ph)
					PH_RLOW:  ph = PH_RWAIT;
					PH_RWAIT: ph = PH_RREC;
					PH_WLOW: begin
						if (bitv)
							ph = PH_WREL;
						else
							fin = next_write_bit();
					end
					PH_WREL:  fin = next_write_bit();
					PH_RDLOW: ph = PH_RDREL;
					PH_RDREL: begin
						if (bit_idx == 3'd7) begin
							read_hold = shift;
							fin = finish_piece();
						end else begin
							bit_idx++;
							ph = PH_RDLOW;
						end
					end
					default: fin = finish_piece();
				endcase
				if (fin) begin
					ph = PH_IDLE;
					r.done = 1'b1;
				end
			end
		end
		r.absent = absent;
		r.rdata = read_hold;
		r.temp = temp_hold;
		return r;
	endfunction

	// line level the sensor would show in the coming tick
	function automatic logic pick_line(line_mode_t m);
		case (m)
			LN_LOW:        return 1'b0;
			LN_HIGH:       return 1'b1;
			LN_PRESENT:    return (ph == PH_RREC) ? 1'b0 : 1'(($urandom));
			LN_ABSENT:     return (ph == PH_RREC) ? 1'b1 : 1'(($urandom));
			LN_FIRST_ONLY: return !(ph == PH_RREC && seq == SEQ_RESET1);
			default:       return 1'(($urandom));
		endcase
	endfunction

	function automatic dir_row_t op_row(row_kind_t k, logic [1:0] op, logic [7:0] wb,
		line_mode_t m, logic typed);
		dir_row_t d;
		d.kind = k;
		d.a = {8'b0, op};
		d.b = {2'b0, wb};
		d.line = m;
		d.typed = typed;
		return d;
	endfunction

	function automatic dir_row_t cfg_row(logic [IDX_W-1:0] idx, logic [TIME_W-1:0] val);
		dir_row_t d;
		d.kind = ROW_CFG;
		d.a = {7'b0, idx};
		d.b = val;
		d.line = LN_RAND;
		d.typed = 1'b0;
		return d;
	endfunction

	function automatic int field_bad(string name, logic [11:0] want, logic [11:0] got);
		if (got !== want) begin
			$error("%s expected %0h got %0h", name, want, got);
			return 1;
		end
		return 0;
	endfunction

	// offer one tick, wait for its transfer, then record what it should yield
	task automatic send_tick(input item_t it, input logic typed);
		int gap;
		tick_result_t r;
		gap = 0;
		while ($urandom_range(99) < send_idle && gap < 40)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, it};
		do @(posedge clk); while (!s_tready);
		r = step_bus_master(it);
		want_q.push_back(typed ? tick_result_t'('0) : r);
		sent_ticks++;
	endtask

	// start an operation and keep ticking until it has finished
	task automatic run_op(input logic [1:0] op, input logic [7:0] wb, input line_mode_t m);
		item_t it;
		it.start_req = 1'b1;
		it.operation = op;
		it.write_byte = wb;
		it.line_level = pick_line(m);
		send_tick(it, 1'b0);
		// starts while busy carry junk and must be ignored
		while (ph != PH_IDLE) begin
			it.start_req = 1'($urandom);
			it.operation = 2'($urandom);
			it.write_byte = 8'($urandom);
			it.line_level = pick_line(m);
			send_tick(it, 1'b0);
		end
		done_ops++;
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (want_q.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [TIME_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_RESET_LOW: tm.reset_low_time = val;
			REG_PRES_WAIT: tm.presence_wait_time = val;
			REG_SLOT:      tm.slot_time = val;
			REG_WR1_LOW:   tm.write_one_low_time = val;
			REG_RD_LOW:    tm.read_low_time = val;
			REG_CONV_WAIT: tm.convert_wait_time = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// result side: check each transfer and pace m_tready
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			got_r = tick_result_t'(m_tdata);
			if (want_q.size() == 0) begin
				$error("result transfer with no expectation waiting");
				mismatches++;
			end else begin
				want_r = want_q.pop_front();
				mismatches += field_bad("bus_pull_low", 12'(want_r.pull), 12'(got_r.pull));
				mismatches += field_bad("busy_res", 12'(want_r.busy), 12'(got_r.busy));
				mismatches += field_bad("done_res", 12'(want_r.done), 12'(got_r.done));
				mismatches += field_bad("no_device", 12'(want_r.absent), 12'(got_r.absent));
				mismatches += field_bad("read_byte", 12'(want_r.rdata), 12'(got_r.rdata));
				mismatches += field_bad("temperature", want_r.temp, got_r.temp);
			end
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall);
		end
	end

	// stimulus
	initial begin
		item_t it;
		int phase_ticks;
		int phase_ops;
		int k;
		int gap;

		// directed rows
		dir_rows.push_back(op_row(ROW_IDLE, OP_RESET, 8'h00, LN_LOW, 1'b1));
		dir_rows.push_back(op_row(ROW_IDLE, OP_TEMP, 8'hFF, LN_HIGH, 1'b1));
		// byte read with the timing registers as they come out of reset
		dir_rows.push_back(op_row(ROW_OP, OP_READ, 8'h00, LN_RAND, 1'b0));
		// fast timing, zero registers read as one tick, unused indexes
		dir_rows.push_back(cfg_row(REG_RESET_LOW, 10'd1));
		dir_rows.push_back(cfg_row(REG_PRES_WAIT, 10'd1));
		dir_rows.push_back(cfg_row(REG_SLOT, 10'd0));
		dir_rows.push_back(cfg_row(REG_WR1_LOW, 10'd0));
		dir_rows.push_back(cfg_row(REG_RD_LOW, 10'd1));
		dir_rows.push_back(cfg_row(REG_CONV_WAIT, 10'd0));
		dir_rows.push_back(cfg_row(3'd6, 10'd1023));
		dir_rows.push_back(cfg_row(3'd7, 10'd0));
		dir_rows.push_back(op_row(ROW_OP, OP_RESET, 8'h00, LN_ABSENT, 1'b0));
		dir_rows.push_back(op_row(ROW_OP, OP_RESET, 8'h00, LN_PRESENT, 1'b0));
		dir_rows.push_back(op_row(ROW_OP, OP_WRITE, 8'h00, LN_RAND, 1'b0));
		dir_rows.push_back(op_row(ROW_OP, OP_WRITE, 8'hFF, LN_RAND, 1'b0));
		dir_rows.push_back(op_row(ROW_OP, OP_READ, 8'h00, LN_LOW, 1'b0));
		dir_rows.push_back(op_row(ROW_OP, OP_READ, 8'h00, LN_HIGH, 1'b0));
		// temperature read: no presence, then absent only on the second reset
		dir_rows.push_back(op_row(ROW_OP, OP_TEMP, 8'h00, LN_HIGH, 1'b0));
		dir_rows.push_back(op_row(ROW_OP, OP_TEMP, 8'h00, LN_FIRST_ONLY, 1'b0));
		dir_rows.push_back(op_row(ROW_OP, OP_TEMP, 8'h00, LN_PRESENT, 1'b0));
		// multi-tick phases with mixed bits
		dir_rows.push_back(cfg_row(REG_RESET_LOW, 10'd5));
		dir_rows.push_back(cfg_row(REG_PRES_WAIT, 10'd3));
		dir_rows.push_back(op_row(ROW_OP, OP_RESET, 8'h00, LN_PRESENT, 1'b0));
		dir_rows.push_back(cfg_row(REG_SLOT, 10'd3));
		dir_rows.push_back(cfg_row(REG_WR1_LOW, 10'd2));
		dir_rows.push_back(cfg_row(REG_RD_LOW, 10'd2));
		dir_rows.push_back(op_row(ROW_OP, OP_WRITE, 8'hA5, LN_RAND, 1'b0));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			case (dir_rows[i].kind)
				ROW_CFG: begin
					wait_idle();
					write_reg(dir_rows[i].a[IDX_W-1:0], dir_rows[i].b);
				end
				ROW_IDLE: begin
					it.start_req = 1'b0;
					it.operation = dir_rows[i].a[1:0];
					it.write_byte = dir_rows[i].b[7:0];
					it.line_level = pick_line(dir_rows[i].line);
					send_tick(it, dir_rows[i].typed);
				end
				default: run_op(dir_rows[i].a[1:0], dir_rows[i].b[7:0], dir_rows[i].line);
			endcase
		end

		// random operations under four pacing modes, new timing each time
		for (int p = 0; p < 4; p++) begin
			wait_idle();
			send_idle = (p == 1) ? 77 : (p == 3) ? 11 : 0;
			recv_stall = (p == 2) ? 77 : (p == 3) ? 11 : 0;
			write_reg(REG_RESET_LOW, TIME_W'($urandom_range(3)));
			write_reg(REG_PRES_WAIT, TIME_W'($urandom_range(3)));
			write_reg(REG_SLOT, TIME_W'($urandom_range(2)));
			write_reg(REG_WR1_LOW, TIME_W'($urandom_range(2)));
			write_reg(REG_RD_LOW, TIME_W'($urandom_range(2)));
			write_reg(REG_CONV_WAIT, TIME_W'($urandom_range(10)));
			// long output hold-off while ticks keep coming
			if (p == 0)
				hold_req = 1'b1;
			phase_ticks = sent_ticks;
			phase_ops = done_ops;
			while (sent_ticks - phase_ticks < 100 || done_ops - phase_ops < 3) begin
				gap = $urandom_range(3);
				for (int g = 0; g < gap; g++) begin
					it.start_req = 1'b0;
					it.operation = 2'($urandom);
					it.write_byte = 8'($urandom);
					it.line_level = 1'($urandom);
					send_tick(it, 1'b0);
				end
				k = $urandom_range(9);
				run_op((k < 3) ? OP_TEMP : (k < 5) ? OP_RESET : (k < 8) ? OP_WRITE : OP_READ,
					8'($urandom), ($urandom_range(99) < 15) ? LN_ABSENT : LN_PRESENT);
			end
		end

		wait_idle();
		repeat (5) @(posedge clk);
		if (mismatches == 0 && want_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// run limit
	initial begin
		#40_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: sim.f
sv/owm_pkg.sv
sv/owm_cfg.sv
sv/owm_step.sv
sv/one_wire_master_temperature_read.sv
bench/tb.sv
